// ===== sv/sacl_pkg.sv =====
// Shared types, codes and defaults for the set-associative LRU cache tag model.
`default_nettype none
package sacl_pkg;

	// Fixed field widths
	localparam int ADDR_W     = 32;
	localparam int FUNC_W     = 2;
	localparam int AGE_W      = 32;
	localparam int CNT_W      = 32;
	localparam int SIB_W      = 3;
	localparam int WAYS_W     = 4;
	localparam int OFF_W      = 5;
	localparam int CFG_DATA_W = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int SB_W       = 6;

	// Parameter defaults
	localparam int MAX_SET_BITS_DEF = 6;
	localparam int MAX_WAYS_DEF     = 8;
	localparam int ADDR_BITS_DEF    = 32;

	// Access kinds
	localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_STORE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_MODIFY = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_IGNORE = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd2;

	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ADDR_W-1:0] address;
	} in_item_t;

	typedef struct packed {
		logic             hit;
		logic             miss;
		logic             evicted;
		logic             last_of_run;
		logic [CNT_W-1:0] total_hits;
		logic [CNT_W-1:0] total_misses;
		logic [CNT_W-1:0] total_evictions;
	} out_item_t;

	// Sequencer to scan unit
	typedef struct packed {
		logic clear;
		logic step;
	} scan_ctl_t;

	// Scan unit summary of one lookup
	typedef struct packed {
		logic hit;
		logic have_empty;
	} scan_res_t;

endpackage
`default_nettype wire

// ===== sv/sacl_tag_ram.sv =====
// Single-port-write, single-port-read line store with registered read data.
`default_nettype none
module sacl_tag_ram #(
	parameter int AW = 9,
	parameter int DW = 65
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/sacl_scan_unit.sv =====
// Per-way match, age update and victim tracking, one way per step.
`default_nettype none
module sacl_scan_unit
	import sacl_pkg::*;
#(
	parameter int TAG_W = 32,
	parameter int WAY_W = 3
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire scan_ctl_t        ctl,
	input  wire logic [WAY_W-1:0] way,
	input  wire logic [TAG_W-1:0] lookup_tag,
	input  wire logic             rd_valid,
	input  wire logic [TAG_W-1:0] rd_tag,
	input  wire logic [AGE_W-1:0] rd_age,
	output logic      [AGE_W-1:0] wb_age,
	output scan_res_t             res,
	output logic      [WAY_W-1:0] victim
);

	logic             hit_q;
	logic             empty_q;
	logic [WAY_W-1:0] empty_way_q;
	logic [WAY_W-1:0] old_way_q;
	logic [AGE_W-1:0] best_q;
	logic             match;

	// First valid matching way hits; all others age, saturating
	assign match  = !hit_q && rd_valid && (rd_tag == lookup_tag);
	assign wb_age = match ? '0 : ((rd_age == AGE_MAX) ? rd_age : rd_age + AGE_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
		end else if (ctl.step) begin
			if (match) begin
				hit_q <= 1'b1;
			end
			if (!rd_valid && !empty_q) begin
				empty_q <= 1'b1;
			end
		end
	end

	// Victim candidates: first empty way, else first way of greatest age
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			if (!rd_valid && !empty_q) begin
				empty_way_q <= way;
			end
			if ((way == '0) || (wb_age > best_q)) begin
				best_q    <= wb_age;
				old_way_q <= way;
			end
		end
	end

	assign res.hit        = hit_q;
	assign res.have_empty = empty_q;
	assign victim         = empty_q ? empty_way_q : old_way_q;

endmodule
`default_nettype wire

// ===== sv/set_assoc_cache_lru_sim.sv =====
// Top level: set-associative LRU cache tag model with a way-serial lookup sequencer.
//
// Each request (load, store or modify on a byte address) is looked up in a
// tag store of 2^MAX_SET_BITS sets by MAX_WAYS ways with LRU ages. A lookup
// walks the active ways of the set one per cycle through a single
// compare/age unit and one memory read port, then posts one result; a
// modify does two lookups and so posts two results. Kind 3 is taken and
// yields nothing. The block takes one request at a time; a finished result
// waits in an output register while the next request is taken. After reset
// a clearing pass zeroes every entry of the store; no request is taken
// during it, configuration writes are.
// Configuration must only be changed while the block is idle.
`default_nettype none
module set_assoc_cache_lru_sim
	import sacl_pkg::*;
#(
	parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
	parameter int MAX_WAYS     = MAX_WAYS_DEF,
	parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SET_AW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WCNT_W = $clog2(MAX_WAYS + 1);
	localparam int TAG_W  = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam int SXW    = (TAG_W > SET_AW) ? TAG_W : SET_AW;
	localparam int DEP_AW = SET_AW + WAY_W;
	localparam int ENT_W  = 1 + TAG_W + AGE_W;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_POST  = 2'd3;

	logic [1:0]          state_q;
	logic [DEP_AW-1:0]   clr_q;
	logic [SIB_W-1:0]    sib_q;
	logic [WAYS_W-1:0]   ways_q;
	logic [OFF_W-1:0]    off_q;
	logic [SET_AW-1:0]   set_q;
	logic [TAG_W-1:0]    tag_q;
	logic                pend2_q;
	logic [WCNT_W-1:0]   rd_way_q;
	logic                rd_vld_s1;
	logic [WAY_W-1:0]    way_s1;
	logic [CNT_W-1:0]    hit_cnt_q;
	logic [CNT_W-1:0]    miss_cnt_q;
	logic [CNT_W-1:0]    ev_cnt_q;
	logic                out_valid_q;
	out_item_t           result_q;

	logic [SB_W-1:0]     s_eff;
	logic [SB_W-1:0]     sb;
	logic [WAYS_W:0]     ways_x;
	logic [WCNT_W-1:0]   e_eff;
	logic [TAG_W-1:0]    addr_m;
	logic [TAG_W-1:0]    set_mask;
	logic [SXW-1:0]      set_ext;
	logic [TAG_W-1:0]    tag_new;

	logic                in_acc;
	logic                lookup_go;
	logic                rd_issue;
	logic                scan_last;
	logic                posting;
	logic                mem_we;
	logic [DEP_AW-1:0]   mem_waddr;
	logic [ENT_W-1:0]    mem_wdata;
	logic [ENT_W-1:0]    mem_rdata;
	logic                rd_valid;
	logic [TAG_W-1:0]    rd_tag;
	logic [AGE_W-1:0]    rd_age;
	logic [AGE_W-1:0]    wb_age;
	scan_ctl_t           scan_ctl;
	scan_res_t           scan_res;
	logic [WAY_W-1:0]    victim;
	logic                ev_now;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sib_q  <= '0;
			ways_q <= WAYS_W'(1);
			off_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_BITS: sib_q  <= cfg_data[SIB_W-1:0];
				CFG_WAYS:     ways_q <= cfg_data[WAYS_W-1:0];
				CFG_OFFSET:   off_q  <= cfg_data[OFF_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective geometry, clamped
	assign s_eff  = (SB_W'(sib_q) > SB_W'(MAX_SET_BITS)) ? SB_W'(MAX_SET_BITS) : SB_W'(sib_q);
	assign sb     = SB_W'(off_q) + s_eff;
	assign ways_x = {1'b0, ways_q};
	always_comb begin
		if (ways_q == '0) begin
			e_eff = WCNT_W'(1);
		end else if (ways_x > (WAYS_W + 1)'(MAX_WAYS)) begin
			e_eff = WCNT_W'(MAX_WAYS);
		end else begin
			e_eff = WCNT_W'(ways_x);
		end
	end

	// Set and tag split of the incoming address
	assign addr_m   = in_data.address[TAG_W-1:0];
	assign set_mask = (TAG_W'(1) << s_eff) - TAG_W'(1);
	assign set_ext  = SXW'((addr_m >> off_q) & set_mask);
	assign tag_new  = (sb >= SB_W'(TAG_W)) ? '0 : (addr_m >> sb);

	// Handshake and sequencing strobes
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign lookup_go = in_acc && (in_data.func != FUNC_IGNORE);
	assign rd_issue  = (state_q == ST_SCAN) && (rd_way_q != e_eff);
	assign scan_last = (state_q == ST_SCAN) && rd_vld_s1 && (rd_way_q == e_eff);
	assign posting   = (state_q == ST_POST) && (!out_valid_q || !out_stall);

	assign scan_ctl.clear = lookup_go || (posting && pend2_q);
	assign scan_ctl.step  = rd_vld_s1;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			pend2_q   <= 1'b0;
			rd_way_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if (rd_issue) begin
				rd_way_q <= rd_way_q + WCNT_W'(1);
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + DEP_AW'(1);
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (lookup_go) begin
						pend2_q  <= (in_data.func == FUNC_MODIFY);
						rd_way_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (posting) begin
						if (pend2_q) begin
							pend2_q  <= 1'b0;
							rd_way_q <= '0;
							state_q  <= ST_SCAN;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Lookup address latch and read pipeline way index
	always_ff @(posedge clk) begin
		if (lookup_go) begin
			set_q <= set_ext[SET_AW-1:0];
			tag_q <= tag_new;
		end
		way_s1 <= rd_way_q[WAY_W-1:0];
	end

	// Line store
	assign rd_valid = mem_rdata[ENT_W-1];
	assign rd_tag   = mem_rdata[ENT_W-2 -: TAG_W];
	assign rd_age   = mem_rdata[AGE_W-1:0];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {set_q, way_s1};
		mem_wdata = {rd_valid, rd_tag, wb_age};
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (rd_vld_s1) begin
			mem_we = 1'b1;
		end else if (posting && !scan_res.hit) begin
			mem_we    = 1'b1;
			mem_waddr = {set_q, victim};
			mem_wdata = {1'b1, tag_q, {AGE_W{1'b0}}};
		end
	end

	sacl_tag_ram #(
		.AW(DEP_AW),
		.DW(ENT_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (rd_issue),
		.raddr({set_q, rd_way_q[WAY_W-1:0]}),
		.rdata(mem_rdata)
	);

	sacl_scan_unit #(
		.TAG_W(TAG_W),
		.WAY_W(WAY_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.way       (way_s1),
		.lookup_tag(tag_q),
		.rd_valid  (rd_valid),
		.rd_tag    (rd_tag),
		.rd_age    (rd_age),
		.wb_age    (wb_age),
		.res       (scan_res),
		.victim    (victim)
	);

	// Running totals
	assign ev_now = !scan_res.hit && !scan_res.have_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			ev_cnt_q   <= '0;
		end else if (posting) begin
			hit_cnt_q  <= hit_cnt_q + CNT_W'(scan_res.hit);
			miss_cnt_q <= miss_cnt_q + CNT_W'(!scan_res.hit);
			ev_cnt_q   <= ev_cnt_q + CNT_W'(ev_now);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (posting) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (posting) begin
			result_q.hit             <= scan_res.hit;
			result_q.miss            <= !scan_res.hit;
			result_q.evicted         <= ev_now;
			result_q.last_of_run     <= !pend2_q;
			result_q.total_hits      <= hit_cnt_q + CNT_W'(scan_res.hit);
			result_q.total_misses    <= miss_cnt_q + CNT_W'(!scan_res.hit);
			result_q.total_evictions <= ev_cnt_q + CNT_W'(ev_now);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = result_q;

endmodule
`default_nettype wire
